// ===== src/asrs_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// asrs_pkg
// Shared types for the aligned sector read splitter: request beat, command
// beat and the result of one split step.
// ----------------------------------------------------------------------------
package asrs_pkg;

  localparam int LBA_W   = 28;
  localparam int CNT_W   = 7;
  localparam int SECT_W  = 9;
  localparam int SKIP_W  = 3;
  localparam int DST_W   = 6;
  localparam int SHIFT_W = 2;
  localparam int UNIT_W  = 4;

  typedef struct packed {
    logic [LBA_W-1:0] start_lba;
    logic [CNT_W-1:0] sector_count;
    logic             dest_odd;
  } req_t;

  typedef struct packed {
    logic [LBA_W-1:0]  cmd_lba;
    logic [SECT_W-1:0] cmd_sectors;
    logic [SKIP_W-1:0] skip_sectors;
    logic [SECT_W-1:0] keep_sectors;
    logic [DST_W-1:0]  dest_sector;
    logic              bounced;
    logic              last;
  } cmd_t;

  typedef struct packed {
    cmd_t             cmd;
    logic [CNT_W-1:0] adv;
    logic [CNT_W-1:0] rem;
  } step_t;

endpackage

// ===== src/asrs_step.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// asrs_step
// Split unit: from the current LBA, remaining count and destination offset,
// form one drive command and the amount it advances the request.
// ----------------------------------------------------------------------------
module asrs_step
  import asrs_pkg::*;
#(
  parameter int CMD_SECTOR_CAP = 256
) (
  input  logic [LBA_W-1:0]   lba,
  input  logic [CNT_W-1:0]   count,
  input  logic               odd,
  input  logic [DST_W-1:0]   dst,
  input  logic [SHIFT_W-1:0] shift,
  output step_t              step
);

  localparam logic [SECT_W-1:0] CAP = SECT_W'(CMD_SECTOR_CAP);

  logic [UNIT_W-1:0] unit;
  logic [SKIP_W-1:0] umask;
  logic [SKIP_W-1:0] off;
  logic [UNIT_W-1:0] avail;
  logic [SECT_W-1:0] cap;
  logic [SECT_W-1:0] bulk;
  logic [SECT_W-1:0] bulk_c;
  logic [CNT_W-1:0]  take;
  logic              fast;

  always_comb begin
    unit   = UNIT_W'(1) << shift;
    umask  = SKIP_W'(unit - UNIT_W'(1));
    off    = lba[SKIP_W-1:0] & umask;
    avail  = unit - {1'b0, off};
    cap    = CAP & ~{{(SECT_W-SKIP_W){1'b0}}, umask};
    bulk   = {2'b00, count} & ~{{(SECT_W-SKIP_W){1'b0}}, umask};
    bulk_c = (bulk > cap) ? cap : bulk;
    take   = (count < CNT_W'(avail)) ? count : CNT_W'(avail);
    fast   = (off == '0) && (count >= CNT_W'(unit)) && !odd;

    step.cmd.dest_sector = dst;
    if (fast) begin
      step.adv                = bulk_c[CNT_W-1:0];
      step.cmd.cmd_lba        = lba;
      step.cmd.cmd_sectors    = bulk_c;
      step.cmd.skip_sectors   = '0;
      step.cmd.keep_sectors   = bulk_c;
      step.cmd.bounced        = 1'b0;
    end else begin
      step.adv                = take;
      step.cmd.cmd_lba        = lba - {{(LBA_W-SKIP_W){1'b0}}, off};
      step.cmd.cmd_sectors    = SECT_W'(unit);
      step.cmd.skip_sectors   = off;
      step.cmd.keep_sectors   = {2'b00, take};
      step.cmd.bounced        = 1'b1;
    end
    step.rem      = count - step.adv;
    step.cmd.last = (step.rem == '0);
  end

endmodule

// ===== src/asrs_seq.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// asrs_seq
// Request sequencer: latches a request, runs the split unit once per cycle
// and registers one command beat per step until the count is spent.
// ----------------------------------------------------------------------------
module asrs_seq
  import asrs_pkg::*;
#(
  parameter int MAX_REQUEST_SECTORS = 64,
  parameter int CMD_SECTOR_CAP      = 256
) (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               start,
  input  req_t               in_item,
  input  logic [SHIFT_W-1:0] shift,
  output logic               busy,
  output logic               out_strobe,
  output cmd_t               out_item
);

  localparam logic [CNT_W-1:0] MAX_CNT = CNT_W'(MAX_REQUEST_SECTORS);

  typedef enum logic [1:0] {
    ST_IDLE = 2'b01,
    ST_RUN  = 2'b10
  } state_t;

  state_t           state_r, state_nxt;
  logic [LBA_W-1:0] lba_r, lba_nxt;
  logic [CNT_W-1:0] count_r, count_nxt;
  logic             odd_r, odd_nxt;
  logic [DST_W-1:0] dst_r, dst_nxt;
  logic             strobe_r, strobe_nxt;
  cmd_t             item_r, item_nxt;
  logic [CNT_W-1:0] sat_cnt;
  step_t            step;

  asrs_step #(
    .CMD_SECTOR_CAP(CMD_SECTOR_CAP)
  ) u_step (
    .lba  (lba_r),
    .count(count_r),
    .odd  (odd_r),
    .dst  (dst_r),
    .shift(shift),
    .step (step)
  );

  assign sat_cnt = (in_item.sector_count > MAX_CNT) ? MAX_CNT : in_item.sector_count;

  always_comb begin
    state_nxt  = state_r;
    lba_nxt    = lba_r;
    count_nxt  = count_r;
    odd_nxt    = odd_r;
    dst_nxt    = dst_r;
    strobe_nxt = 1'b0;
    item_nxt   = step.cmd;
    unique case (state_r)
      ST_IDLE: begin
        if (start && (sat_cnt != '0)) begin
          state_nxt = ST_RUN;
          lba_nxt   = in_item.start_lba;
          count_nxt = sat_cnt;
          odd_nxt   = in_item.dest_odd;
          dst_nxt   = '0;
        end
      end
      ST_RUN: begin
        strobe_nxt = 1'b1;
        lba_nxt    = lba_r + LBA_W'(step.adv);
        count_nxt  = step.rem;
        dst_nxt    = dst_r + step.adv[DST_W-1:0];
        if (step.rem == '0) begin
          state_nxt = ST_IDLE;
        end
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r  <= ST_IDLE;
      strobe_r <= 1'b0;
      count_r  <= '0;
    end else begin
      state_r  <= state_nxt;
      strobe_r <= strobe_nxt;
      count_r  <= count_nxt;
    end
  end

  always_ff @(posedge clk) begin
    lba_r  <= lba_nxt;
    odd_r  <= odd_nxt;
    dst_r  <= dst_nxt;
    item_r <= item_nxt;
  end

  assign busy       = (state_r == ST_RUN);
  assign out_strobe = strobe_r;
  assign out_item   = item_r;

`ifndef SYNTH
  a_strobe_follows_run: assert property (@(posedge clk) disable iff (!rst_n)
    out_strobe |-> $past(busy))
    else $error("command beat without a running request");

  a_run_has_count: assert property (@(posedge clk) disable iff (!rst_n)
    busy |-> (count_r != '0))
    else $error("running with no sectors left");

  a_last_ends_run: assert property (@(posedge clk) disable iff (!rst_n)
    (out_strobe && out_item.last) |-> !busy)
    else $error("last beat while still running");

  a_keep_nonzero: assert property (@(posedge clk) disable iff (!rst_n)
    out_strobe |-> (out_item.keep_sectors != '0))
    else $error("command beat keeps no sectors");

  a_accept_runs: assert property (@(posedge clk) disable iff (!rst_n)
    (start && !busy && (sat_cnt != '0)) |=> busy)
    else $error("accepted request did not start");
`endif

endmodule

// ===== src/aligned_sector_read_splitter_top.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// aligned_sector_read_splitter_top
// Splits a logical read request into physically aligned drive commands.
// ----------------------------------------------------------------------------
// A request is taken when start is high and busy is low. A request whose
// count (saturated to MAX_REQUEST_SECTORS) is zero gives no beats and leaves
// busy low. Otherwise busy stays high while its N commands are formed;
// the shared split unit forms one command per cycle and out_strobe marks
// each beat for one cycle, starting once the run state is entered and the
// first command registered. N is at most the sector count (64). The
// receiver must take every beat as it comes; there is no stall. The user
// must write the physical sector shift (reset value 1) through cfg_we only
// while busy is low and no beat is pending; the block does not enforce it.
module aligned_sector_read_splitter_top
  import asrs_pkg::*;
#(
  parameter int MAX_REQUEST_SECTORS = 64,
  parameter int CMD_SECTOR_CAP      = 256
) (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               start,
  output logic               busy,
  input  req_t               in_item,
  output logic               out_strobe,
  output cmd_t               out_item,
  input  logic               cfg_we,
  input  logic [SHIFT_W-1:0] cfg_wdata
);

  logic [SHIFT_W-1:0] shift_r, shift_nxt;

  assign shift_nxt = cfg_we ? cfg_wdata : shift_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      shift_r <= SHIFT_W'(1);
    end else begin
      shift_r <= shift_nxt;
    end
  end

  asrs_seq #(
    .MAX_REQUEST_SECTORS(MAX_REQUEST_SECTORS),
    .CMD_SECTOR_CAP     (CMD_SECTOR_CAP)
  ) u_seq (
    .clk       (clk),
    .rst_n     (rst_n),
    .start     (start),
    .in_item   (in_item),
    .shift     (shift_r),
    .busy      (busy),
    .out_strobe(out_strobe),
    .out_item  (out_item)
  );

endmodule

// ===== verif/aligned_sector_read_splitter_checker.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// aligned_sector_read_splitter_checker
// Watches the request, command and sector-shift ports of the splitter. It
// keeps its own copy of the sector shift and splits each accepted request
// into the drive commands the block must emit. Each command beat is compared
// field by field with the oldest outstanding command.
// ----------------------------------------------------------------------------
module aligned_sector_read_splitter_checker
  import asrs_pkg::*;
#(
  parameter int MAX_REQUEST_SECTORS = 64,
  parameter int CMD_SECTOR_CAP      = 256
) (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               start,
  input  logic               busy,
  input  req_t               in_item,
  input  logic               out_strobe,
  input  cmd_t               out_item,
  input  logic               cfg_we,
  input  logic [SHIFT_W-1:0] cfg_wdata,
  input  logic               end_check,
  output int                 fail_count,
  output int                 pending,
  output int                 beats_seen
);

  logic [SHIFT_W-1:0] sector_shift;
  cmd_t               outstanding_cmds[$];

  task automatic split_request(input req_t r);
    logic [LBA_W-1:0] lba;
    int               remaining;
    int               unit;
    int               umask;
    int               cap;
    int               offset;
    int               take;
    int               dst;
    cmd_t             c;
    lba       = r.start_lba;
    remaining = (r.sector_count > MAX_REQUEST_SECTORS) ? MAX_REQUEST_SECTORS
                                                       : int'(r.sector_count);
    unit      = 1 << sector_shift;
    umask     = unit - 1;
    cap       = CMD_SECTOR_CAP & ~umask;
    if (cap == 0) begin
      cap = unit;
    end
    dst = 0;
    while (remaining > 0) begin
      offset = int'(lba) & umask;
      c      = '0;
      if (offset == 0 && remaining >= unit && !r.dest_odd) begin
        take = remaining & ~umask;
        if (take > cap) begin
          take = cap;
        end
        c.cmd_lba      = lba;
        c.cmd_sectors  = SECT_W'(take);
        c.skip_sectors = '0;
        c.keep_sectors = SECT_W'(take);
        c.bounced      = 1'b0;
      end else begin
        take = (remaining < unit - offset) ? remaining : unit - offset;
        c.cmd_lba      = LBA_W'(lba - offset);
        c.cmd_sectors  = SECT_W'(unit);
        c.skip_sectors = SKIP_W'(offset);
        c.keep_sectors = SECT_W'(take);
        c.bounced      = 1'b1;
      end
      remaining     -= take;
      c.dest_sector  = DST_W'(dst);
      c.last         = (remaining == 0);
      outstanding_cmds.push_back(c);
      lba  = LBA_W'(lba + take);
      dst += take;
    end
  endtask

  task automatic check_field(input string name, input logic [31:0] want,
                             input logic [31:0] got);
    if (want !== got) begin
      $error("%s mismatch: expected 0x%0h, got 0x%0h", name, want, got);
      fail_count++;
    end
  endtask

  always @(posedge clk) begin
    cmd_t want;
    if (!rst_n) begin
      sector_shift <= 2'd1;
      fail_count   = 0;
      beats_seen   = 0;
      outstanding_cmds.delete();
    end else begin
      if (out_strobe) begin
        beats_seen++;
        if (outstanding_cmds.size() == 0) begin
          $error("command beat with none outstanding: lba 0x%0h", out_item.cmd_lba);
          fail_count++;
        end else begin
          want = outstanding_cmds.pop_front();
          check_field("cmd_lba", 32'(want.cmd_lba), 32'(out_item.cmd_lba));
          check_field("cmd_sectors", 32'(want.cmd_sectors), 32'(out_item.cmd_sectors));
          check_field("skip_sectors", 32'(want.skip_sectors), 32'(out_item.skip_sectors));
          check_field("keep_sectors", 32'(want.keep_sectors), 32'(out_item.keep_sectors));
          check_field("dest_sector", 32'(want.dest_sector), 32'(out_item.dest_sector));
          check_field("bounced", 32'(want.bounced), 32'(out_item.bounced));
          check_field("last", 32'(want.last), 32'(out_item.last));
        end
      end
      if (start && !busy) begin
        split_request(in_item);
      end
      if (cfg_we) begin
        sector_shift <= cfg_wdata;
      end
      if (end_check && outstanding_cmds.size() != 0) begin
        $error("%0d commands never emitted", outstanding_cmds.size());
        fail_count += outstanding_cmds.size();
        outstanding_cmds.delete();
      end
    end
    pending = outstanding_cmds.size();
  end

endmodule

// ===== verif/tb_aligned_sector_read_splitter_top.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_aligned_sector_read_splitter_top
// Drives read requests into the splitter under every sector shift: a short
// directed set of edge cases, then random phases with varying sender idling.
// A checker beside the block predicts and compares every command beat.
// ----------------------------------------------------------------------------
module tb_aligned_sector_read_splitter_top;
  import asrs_pkg::*;

  localparam int CYCLE_LIMIT      = 400000;
  localparam int SETTLE_CYCLES    = 8;
  localparam int ITEMS_PER_PHASE  = 66;
  localparam int NUM_PHASES       = 6;

  logic               clk        = 1'b0;
  logic               rst_n      = 1'b0;
  logic               start      = 1'b0;
  logic               busy;
  req_t               in_item    = '0;
  logic               out_strobe;
  cmd_t               out_item;
  logic               cfg_we     = 1'b0;
  logic [SHIFT_W-1:0] cfg_wdata  = '0;
  logic               end_check  = 1'b0;

  int fail_count;
  int pending;
  int beats_seen;
  int requests_sent   = 0;
  int cycle_count     = 0;
  int sender_idle_pct = 0;

  always begin
    #4 clk = 1'b1;
    #4 clk = 1'b0;
  end

  aligned_sector_read_splitter_top dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .start     (start),
    .busy      (busy),
    .in_item   (in_item),
    .out_strobe(out_strobe),
    .out_item  (out_item),
    .cfg_we    (cfg_we),
    .cfg_wdata (cfg_wdata)
  );

  aligned_sector_read_splitter_checker u_checker (
    .clk       (clk),
    .rst_n     (rst_n),
    .start     (start),
    .busy      (busy),
    .in_item   (in_item),
    .out_strobe(out_strobe),
    .out_item  (out_item),
    .cfg_we    (cfg_we),
    .cfg_wdata (cfg_wdata),
    .end_check (end_check),
    .fail_count(fail_count),
    .pending   (pending),
    .beats_seen(beats_seen)
  );

  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("FAIL aligned_sector_read_splitter_top");
      $finish;
    end
  end

  function automatic req_t mk_req(input logic [LBA_W-1:0] lba,
                                  input logic [CNT_W-1:0] cnt, input logic odd);
    req_t r;
    r.start_lba    = lba;
    r.sector_count = cnt;
    r.dest_odd     = odd;
    return r;
  endfunction

  function automatic req_t random_request();
    req_t r;
    int   pick;
    r.start_lba = LBA_W'($urandom);
    if ($urandom_range(1) == 1) begin
      r.start_lba[2:0] = '0;
    end
    if ($urandom_range(19) == 0) begin
      r.start_lba = {LBA_W{1'b1}} - LBA_W'($urandom_range(70));
    end
    pick = $urandom_range(99);
    if (pick < 70) begin
      r.sector_count = CNT_W'($urandom_range(64, 1));
    end else if (pick < 85) begin
      r.sector_count = CNT_W'($urandom_range(8, 1));
    end else if (pick < 96) begin
      r.sector_count = CNT_W'($urandom_range(127, 65));
    end else begin
      r.sector_count = '0;
    end
    r.dest_odd = ($urandom_range(99) < 25);
    return r;
  endfunction

  // hold the request until the block takes it
  task automatic send_request(input req_t r);
    while ($urandom_range(99) < sender_idle_pct) begin
      start = 1'b0;
      @(negedge clk);
    end
    in_item = r;
    start   = 1'b1;
    while (busy) @(negedge clk);
    @(negedge clk);
    requests_sent++;
  endtask

  // drop start and wait for every outstanding beat
  task automatic settle();
    start = 1'b0;
    while (pending != 0 || busy) @(negedge clk);
    repeat (SETTLE_CYCLES) @(negedge clk);
  endtask

  task automatic write_shift(input logic [SHIFT_W-1:0] value);
    settle();
    cfg_wdata = value;
    cfg_we    = 1'b1;
    @(negedge clk);
    cfg_we    = 1'b0;
  endtask

  initial begin
    logic [SHIFT_W-1:0] phase_shift[NUM_PHASES] = '{2'd0, 2'd3, 2'd1, 2'd2, 2'd3, 2'd0};
    repeat (7) @(posedge clk);
    @(negedge clk);
    rst_n = 1'b1;
    @(negedge clk);

    sender_idle_pct = 27;
    send_request(mk_req(28'h0000000, 7'd0, 1'b0));
    send_request(mk_req(28'h0000000, 7'd1, 1'b0));
    send_request(mk_req(28'h0000000, 7'd2, 1'b0));
    send_request(mk_req(28'h0000000, 7'd64, 1'b0));
    send_request(mk_req(28'h0000001, 7'd64, 1'b0));
    send_request(mk_req(28'h0000001, 7'd64, 1'b1));
    send_request(mk_req(28'h0000000, 7'd127, 1'b0));
    send_request(mk_req(28'h0000000, 7'd65, 1'b0));
    send_request(mk_req(28'hFFFFFFF, 7'd64, 1'b0));
    send_request(mk_req(28'hFFFFFFE, 7'd64, 1'b0));
    send_request(mk_req(28'hFFFFFFF, 7'd1, 1'b1));
    send_request(mk_req(28'hAAAAAAA, 7'd64, 1'b1));
    send_request(mk_req(28'h5555555, 7'd127, 1'b0));
    write_shift(2'd0);
    send_request(mk_req(28'h0000007, 7'd64, 1'b0));
    send_request(mk_req(28'hFFFFFFF, 7'd2, 1'b1));
    write_shift(2'd3);
    send_request(mk_req(28'h0000003, 7'd64, 1'b0));
    send_request(mk_req(28'h0000008, 7'd7, 1'b0));
    send_request(mk_req(28'h0000008, 7'd64, 1'b0));
    send_request(mk_req(28'hFFFFFFC, 7'd64, 1'b0));
    send_request(mk_req(28'h0000000, 7'd9, 1'b1));
    write_shift(2'd2);
    send_request(mk_req(28'h0000002, 7'd5, 1'b0));
    send_request(mk_req(28'hFFFFFFD, 7'd127, 1'b0));

    for (int p = 0; p < NUM_PHASES; p++) begin
      write_shift(phase_shift[p]);
      sender_idle_pct = (p < 2) ? 27 : (p < 4) ? 58 : 0;
      for (int i = 0; i < ITEMS_PER_PHASE; i++) begin
        if (i == ITEMS_PER_PHASE / 2) begin
          settle();
        end
        send_request(random_request());
      end
    end

    settle();
    end_check = 1'b1;
    @(negedge clk);
    end_check = 1'b0;
    @(negedge clk);

    $display("Run covered %0d requests and %0d drive commands over sector shifts 0 to 3,",
             requests_sent, beats_seen);
    $display("with the sender idling at 27, 58 and 0 percent of cycles.");
    if (fail_count == 0) begin
      $display("PASS aligned_sector_read_splitter_top");
    end else begin
      $display("FAIL aligned_sector_read_splitter_top");
    end
    $finish;
  end

endmodule
